[design/mmt_pkg.sv]
// ----------------------------------------------------------------------------
// Multimap table package
// Shared widths, request and status codes, and the stored entry type.
// ----------------------------------------------------------------------------
package mmt_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_LOOKUP  = 2'd1;
    localparam logic [1:0] REQ_DROPONE = 2'd2;
    localparam logic [1:0] REQ_DROPKEY = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic [DATA_WIDTH-1:0] key;
        logic [DATA_WIDTH-1:0] val;
    } entry_t;

    // Rotate moves every cell one place toward the head; pack closes the
    // first gap by moving only the cells at and behind it.
    typedef struct packed {
        logic rotate;
        logic pack;
    } cell_ctl_t;

endpackage

[design/mmt_cell.sv]
// ----------------------------------------------------------------------------
// Multimap table cell
// Holds one key and value pair and takes its neighbor's pair when it shifts.
// ----------------------------------------------------------------------------
module mmt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mmt_pkg::cell_ctl_t ctl,
    input  mmt_pkg::entry_t    next_in,
    input  logic               hole_in,
    output mmt_pkg::entry_t    data,
    output logic               hole_out
);
    import mmt_pkg::*;

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic                  shift;

    // A gap at or ahead of this cell makes it move during packing.
    assign hole_out = hole_in | ~valid_reg;
    assign shift    = ctl.rotate | (ctl.pack & hole_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= next_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= next_in.key;
            val_reg <= next_in.val;
        end
    end

    assign data = '{valid: valid_reg, key: key_reg, val: val_reg};

endmodule

[design/multimap_table_engine.sv]
// ----------------------------------------------------------------------------
// Multimap table engine
// Key and value pairs in insertion order, held in a ring of cells.
// ----------------------------------------------------------------------------
// An insert into a full table answers in the cycle after the transfer.
// Insert makes one pass round the ring; remove-pair adds packing when found.
// Lookup and remove-key make a counting pass, the last for a missing key, then
// a second; remove-key then packs the ring. One request runs at a time.
// Results are strobed for one cycle by result_valid; the receiver cannot stall.
// Reset empties the table at once; no clearing pass is needed.
module multimap_table_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           req_type,
    input  logic signed [mmt_pkg::DATA_WIDTH-1:0] key,
    input  logic signed [mmt_pkg::DATA_WIDTH-1:0] value,
    output logic                                 result_valid,
    output logic signed [mmt_pkg::DATA_WIDTH-1:0] out_value,
    output logic [1:0]                           status,
    output logic                                 last,
    output logic [mmt_pkg::CNT_W-1:0]            distinct_keys,
    output logic                                 is_empty
);
    import mmt_pkg::*;

    // States of the request sequencer.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WORK = 2'd2;
    localparam logic [1:0] S_PACK = 2'd3;

    localparam entry_t EMPTY = '{valid: 1'b0, key: '0, val: '0};

    logic [1:0]            state_reg, state_next;
    logic [IDX_W-1:0]      t_reg, t_next;
    logic [CNT_W-1:0]      km_reg, km_next;
    logic [CNT_W-1:0]      em_reg, em_next;
    logic                  found_reg, found_next;
    logic [CNT_W-1:0]      pc_reg, pc_next;
    logic [CNT_W-1:0]      kc_reg, kc_next;
    logic [1:0]            req_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] value_reg;

    logic                  res_v;
    logic [DATA_WIDTH-1:0] res_val;
    logic [1:0]            res_st;
    logic                  res_last;

    logic                  result_valid_reg;
    logic [DATA_WIDTH-1:0] out_value_reg;
    logic [1:0]            status_reg;
    logic                  last_reg;
    logic [CNT_W-1:0]      distinct_reg;
    logic                  empty_reg;

    cell_ctl_t             ctl;
    entry_t                feed;
    entry_t                head;
    entry_t                cell_data [CAPACITY];
    logic                  holes [CAPACITY];

    logic                  key_hit;
    logic                  pair_hit;
    logic                  drop;
    logic                  t_last;
    logic [CNT_W-1:0]      km_inc;
    logic                  accept;

    // The ring: cell 0 is the head, the last cell takes the feed.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t nin;
            logic   hin;
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign nin = feed;
            end
            else
            begin : g_body
                assign nin = cell_data[gi + 1];
            end
            if (gi == 0)
            begin : g_first
                assign hin = 1'b0;
            end
            else
            begin : g_rest
                assign hin = holes[gi - 1];
            end
            mmt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .next_in  (nin),
                .hole_in  (hin),
                .data     (cell_data[gi]),
                .hole_out (holes[gi])
            );
        end
    endgenerate

    assign head     = cell_data[0];
    assign key_hit  = head.valid && (head.key == key_reg);
    assign pair_hit = key_hit && (head.val == value_reg);
    assign t_last   = (t_reg == IDX_W'(CAPACITY - 1));
    assign km_inc   = km_reg + CNT_W'(key_hit);
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_last ? '0 : t_reg + IDX_W'(1);
        km_next    = km_reg;
        em_next    = em_reg;
        found_next = found_reg;
        pc_next    = pc_reg;
        kc_next    = kc_reg;
        feed       = head;
        drop       = 1'b0;
        ctl        = '{rotate: 1'b0, pack: 1'b0};
        res_v      = 1'b0;
        res_val    = '0;
        res_st     = ST_OK;
        res_last   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                t_next     = '0;
                km_next    = '0;
                em_next    = '0;
                found_next = 1'b0;
                if (start)
                begin
                    case (req_type)
                        REQ_INSERT:
                        begin
                            if (pc_reg == CNT_W'(CAPACITY))
                            begin
                                res_v    = 1'b1;
                                res_st   = ST_FULL;
                                res_last = 1'b1;
                            end
                            else
                            begin
                                state_next = S_WORK;
                            end
                        end
                        REQ_DROPONE:
                        begin
                            state_next = S_WORK;
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end

            // Counting pass: learn how many values the key holds.
            S_SCAN:
            begin
                ctl.rotate = 1'b1;
                km_next    = km_inc;
                if (t_last)
                begin
                    if (km_inc == '0)
                    begin
                        res_v      = 1'b1;
                        res_st     = ST_NOTFOUND;
                        res_last   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_WORK;
                        if (req_reg == REQ_DROPKEY)
                        begin
                            pc_next = pc_reg - km_inc;
                            kc_next = kc_reg - CNT_W'(1);
                        end
                    end
                end
            end

            S_WORK:
            begin
                ctl.rotate = 1'b1;
                case (req_reg)
                    REQ_INSERT:
                    begin
                        // The new pair lands in the first free slot.
                        km_next = km_inc;
                        if (CNT_W'(t_reg) == pc_reg)
                        begin
                            feed = '{valid: 1'b1, key: key_reg, val: value_reg};
                        end
                        if (t_last)
                        begin
                            pc_next    = pc_reg + CNT_W'(1);
                            kc_next    = kc_reg + CNT_W'(km_inc == '0);
                            res_v      = 1'b1;
                            res_last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    REQ_DROPONE:
                    begin
                        drop       = pair_hit && !found_reg;
                        km_next    = km_inc;
                        found_next = found_reg | drop;
                        if (drop)
                        begin
                            feed = EMPTY;
                        end
                        if (t_last)
                        begin
                            res_v    = 1'b1;
                            res_last = 1'b1;
                            if (found_next)
                            begin
                                pc_next = pc_reg - CNT_W'(1);
                                if (km_inc == CNT_W'(1))
                                begin
                                    kc_next = kc_reg - CNT_W'(1);
                                end
                                km_next    = CNT_W'(1);
                                state_next = S_PACK;
                            end
                            else
                            begin
                                res_st     = ST_NOTFOUND;
                                state_next = S_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        // Lookup and remove-key stream each value as it passes.
                        if (key_hit)
                        begin
                            res_v    = 1'b1;
                            res_val  = head.val;
                            res_last = ((em_reg + CNT_W'(1)) == km_reg);
                            em_next  = em_reg + CNT_W'(1);
                            if (req_reg == REQ_DROPKEY)
                            begin
                                feed = EMPTY;
                            end
                        end
                        if (t_last)
                        begin
                            state_next = (req_reg == REQ_DROPKEY) ? S_PACK : S_IDLE;
                        end
                    end
                endcase
            end

            // Each cycle closes one slot of the first gap in the ring.
            S_PACK:
            begin
                ctl.pack = 1'b1;
                feed     = EMPTY;
                km_next  = km_reg - CNT_W'(1);
                if (km_reg == CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            t_reg            <= '0;
            km_reg           <= '0;
            em_reg           <= '0;
            found_reg        <= 1'b0;
            pc_reg           <= '0;
            kc_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            t_reg            <= t_next;
            km_reg           <= km_next;
            em_reg           <= em_next;
            found_reg        <= found_next;
            pc_reg           <= pc_next;
            kc_reg           <= kc_next;
            result_valid_reg <= res_v;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            key_reg   <= key;
            value_reg <= value;
        end
        if (res_v)
        begin
            out_value_reg <= res_val;
            status_reg    <= res_st;
            last_reg      <= res_last;
            distinct_reg  <= kc_next;
            empty_reg     <= (pc_next == '0);
        end
    end

    assign result_valid  = result_valid_reg;
    assign out_value     = out_value_reg;
    assign status        = status_reg;
    assign last          = last_reg;
    assign distinct_keys = distinct_reg;
    assign is_empty      = empty_reg;

endmodule
